@@ hw/rtl/abrc_pkg.sv @@
// Shared types and constants for the atom bounds and residue census block.
package abrc_pkg;

	localparam int unsigned NAME_W  = 40;
	localparam int unsigned COORD_W = 25;
	localparam int unsigned RNUM_W  = 17;
	localparam int unsigned CNT_W   = 24;
	localparam int unsigned DEF_TYPE_SLOTS   = 16;
	localparam int unsigned DEF_SELECT_NAMES = 4;

	localparam logic [2:0] REG_WALL_AXIS   = 3'd0;
	localparam logic [2:0] REG_WALL_MIDDLE = 3'd1;
	localparam logic [2:0] REG_SEL_0       = 3'd2;
	localparam logic [2:0] REG_SEL_3       = 3'd5;

	localparam logic [2:0] KIND_CHAN_LO = 3'd0;
	localparam logic [2:0] KIND_CHAN_HI = 3'd1;
	localparam logic [2:0] KIND_SEL_LO  = 3'd2;
	localparam logic [2:0] KIND_SEL_HI  = 3'd3;
	localparam logic [2:0] KIND_COUNT   = 3'd4;
	localparam logic [2:0] KIND_TYPE    = 3'd5;

	localparam logic [1:0] ERR_SIZE = 2'b01;
	localparam logic [1:0] ERR_FULL = 2'b10;

	// controller -> datapath
	typedef struct packed {
		logic       atom;     // apply the held atom
		logic       close;    // close the open run into the type table
		logic       emit;     // load output register from the record mux
		logic [8:0] rec;      // record number within the report
		logic       last;
		logic       clear;    // frame state back to reset
	} abrc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [8:0] types;    // slots in use
	} abrc_sts_t;

	function automatic logic [NAME_W-1:0] upcase(input logic [NAME_W-1:0] n);
		logic [NAME_W-1:0] r;
		logic [7:0] b;
		r = '0;
		for (int i = 0; i < NAME_W / 8; i++) begin
			b = n[8*i +: 8];
			if (b >= 8'h61 && b <= 8'h7a) b = b - 8'd32;
			r[8*i +: 8] = b;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/abrc_dpath.sv @@
// Datapath: bounds, run tracking, type table and report record mux.
module abrc_dpath import abrc_pkg::*; #(
	parameter int unsigned TYPE_SLOTS   = DEF_TYPE_SLOTS,
	parameter int unsigned SELECT_NAMES = DEF_SELECT_NAMES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [2:0]                cfg_index,
	input  logic [NAME_W-1:0]         cfg_data,
	input  logic                      in_load,
	input  logic [RNUM_W-1:0]         in_num,
	input  logic [NAME_W-1:0]         in_name,
	input  logic signed [COORD_W-1:0] in_x,
	input  logic signed [COORD_W-1:0] in_y,
	input  logic signed [COORD_W-1:0] in_z,
	input  abrc_cmd_t                 cmd,
	output abrc_sts_t                 sts,
	output logic [2:0]                o_kind,
	output logic [3:0]                o_slot,
	output logic [COORD_W-1:0]        o_coord,
	output logic                      o_found,
	output logic [CNT_W-1:0]          o_count,
	output logic [RNUM_W-1:0]         o_apm,
	output logic [NAME_W-1:0]         o_name,
	output logic                      o_sel,
	output logic [1:0]                o_err,
	output logic                      o_last
);
	localparam int unsigned SW = (TYPE_SLOTS > 1) ? $clog2(TYPE_SLOTS) : 1;

	logic [1:0]                wall_axis_q;
	logic signed [COORD_W-1:0] wall_mid_q;
	logic [NAME_W-1:0]         sel_name_q [SELECT_NAMES];

	logic [RNUM_W-1:0]         num_q;
	logic [NAME_W-1:0]         name_q;
	logic signed [COORD_W-1:0] pos_q [3];

	logic signed [COORD_W-1:0] sb_q [6];
	logic signed [COORD_W-1:0] cb_q [6];
	logic [5:0]                cf_q;
	logic [CNT_W-1:0]          sel_tot_q;
	logic                      run_act_q;
	logic [RNUM_W-1:0]         run_num_q;
	logic [NAME_W-1:0]         run_name_q;
	logic [RNUM_W-1:0]         run_tot_q;
	logic [NAME_W-1:0]         tn_q  [TYPE_SLOTS];
	logic [CNT_W-1:0]          tm_q  [TYPE_SLOTS];
	logic [RNUM_W-1:0]         ta_q  [TYPE_SLOTS];
	logic [8:0]                used_q;
	logic [1:0]                err_q;

	function automatic logic is_sel(input logic [NAME_W-1:0] n,
			input logic [NAME_W-1:0] s [SELECT_NAMES]);
		logic r;
		r = 1'b0;
		for (int k = 0; k < SELECT_NAMES; k++)
			if (s[k] == n) r = 1'b1;
		return r && (n != '0);
	endfunction

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_axis_q <= 2'd2;
			wall_mid_q  <= '0;
			for (int k = 0; k < SELECT_NAMES; k++) sel_name_q[k] <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_WALL_AXIS) wall_axis_q <= cfg_data[1:0];
			if (cfg_index == REG_WALL_MIDDLE) wall_mid_q <= cfg_data[COORD_W-1:0];
			for (int k = 0; k < SELECT_NAMES; k++)
				if (cfg_index == REG_SEL_0 + 3'(k)) sel_name_q[k] <= cfg_data;
		end
	end

	// atom holding register
	always_ff @(posedge clk) begin
		if (in_load) begin
			num_q    <= in_num;
			name_q   <= upcase(in_name);
			pos_q[0] <= in_x;
			pos_q[1] <= in_y;
			pos_q[2] <= in_z;
		end
	end

	// type lookup for the open run
	logic          hit;
	logic [SW-1:0] hit_idx;
	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		for (int i = TYPE_SLOTS - 1; i >= 0; i--)
			if (9'(i) < used_q && tn_q[i] == run_name_q) begin
				hit = 1'b1;
				hit_idx = SW'(i);
			end
	end

	logic new_run, atom_sel, close_go;
	assign new_run  = !run_act_q || num_q != run_num_q || name_q != run_name_q;
	assign atom_sel = is_sel(name_q, sel_name_q);
	// open run ends at a change of residue or at frame end
	assign close_go = run_act_q && run_tot_q != '0 && (cmd.close || (cmd.atom && new_run));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cf_q <= '0; sel_tot_q <= '0; run_act_q <= 1'b0;
			run_num_q <= '0; run_name_q <= '0; run_tot_q <= '0;
			used_q <= '0; err_q <= '0;
			for (int k = 0; k < 6; k++) begin sb_q[k] <= '0; cb_q[k] <= '0; end
		end else if (cmd.clear) begin
			cf_q <= '0; sel_tot_q <= '0; run_act_q <= 1'b0;
			run_num_q <= '0; run_name_q <= '0; run_tot_q <= '0;
			used_q <= '0; err_q <= '0;
		end else begin
			if (close_go) begin
				if (hit) begin
					if (ta_q[hit_idx] != run_tot_q) err_q <= err_q | ERR_SIZE;
				end else if (used_q < 9'(TYPE_SLOTS)) used_q <= used_q + 9'd1;
				else err_q <= err_q | ERR_FULL;
			end
			if (cmd.close) begin
				run_act_q <= 1'b0;
			end else if (cmd.atom) begin
				if (new_run) begin
					run_act_q <= 1'b1; run_num_q <= num_q;
					run_name_q <= name_q; run_tot_q <= RNUM_W'(1);
				end else if (run_tot_q != '1) run_tot_q <= run_tot_q + 1'b1;
				if (atom_sel) begin
					for (int k = 0; k < 3; k++) begin
						if (sel_tot_q == '0 || pos_q[k] < sb_q[k]) sb_q[k] <= pos_q[k];
						if (sel_tot_q == '0 || pos_q[k] > sb_q[k+3]) sb_q[k+3] <= pos_q[k];
					end
					if (sel_tot_q != '1) sel_tot_q <= sel_tot_q + 1'b1;
				end else begin
					for (int k = 0; k < 3; k++) begin
						if (wall_axis_q == 2'(k)) begin
							if (pos_q[k] < wall_mid_q && (!cf_q[k] || pos_q[k] > cb_q[k])) begin
								cb_q[k] <= pos_q[k]; cf_q[k] <= 1'b1;
							end
							if (pos_q[k] > wall_mid_q
									&& (!cf_q[k+3] || pos_q[k] < cb_q[k+3])) begin
								cb_q[k+3] <= pos_q[k]; cf_q[k+3] <= 1'b1;
							end
						end else begin
							if (!cf_q[k] || pos_q[k] < cb_q[k]) begin
								cb_q[k] <= pos_q[k]; cf_q[k] <= 1'b1;
							end
							if (!cf_q[k+3] || pos_q[k] > cb_q[k+3]) begin
								cb_q[k+3] <= pos_q[k]; cf_q[k+3] <= 1'b1;
							end
						end
					end
				end
			end
		end
	end

	// type table payload, no reset
	always_ff @(posedge clk) begin
		if (close_go && !cmd.clear) begin
			if (hit) begin
				if (ta_q[hit_idx] == run_tot_q && tm_q[hit_idx] != '1)
					tm_q[hit_idx] <= tm_q[hit_idx] + 1'b1;
			end else if (used_q < 9'(TYPE_SLOTS)) begin
				tn_q[used_q[SW-1:0]] <= run_name_q;
				tm_q[used_q[SW-1:0]] <= CNT_W'(1);
				ta_q[used_q[SW-1:0]] <= run_tot_q;
			end
		end
	end

	assign sts.types = used_q;

	// record mux into the output register
	logic [2:0] k6;
	logic [SW-1:0] ti;
	assign ti = cmd.rec[SW-1:0] - SW'(13);
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			o_err  <= err_q;
			o_last <= cmd.last;
			o_coord <= '0; o_found <= 1'b0; o_count <= '0;
			o_apm <= '0; o_name <= '0; o_sel <= 1'b0; o_slot <= '0;
			if (cmd.rec < 9'd6) begin
				o_kind  <= (cmd.rec < 9'd3) ? KIND_CHAN_LO : KIND_CHAN_HI;
				o_slot  <= (cmd.rec < 9'd3) ? cmd.rec[3:0] : cmd.rec[3:0] - 4'd3;
				o_found <= cf_q[cmd.rec[2:0]];
				o_coord <= cf_q[cmd.rec[2:0]] ? cb_q[cmd.rec[2:0]] : '0;
			end else if (cmd.rec < 9'd12) begin
				o_kind  <= (cmd.rec < 9'd9) ? KIND_SEL_LO : KIND_SEL_HI;
				o_slot  <= (cmd.rec < 9'd9) ? cmd.rec[3:0] - 4'd6 : cmd.rec[3:0] - 4'd9;
				o_found <= sel_tot_q != '0;
				o_coord <= (sel_tot_q != '0) ? sb_q[k6] : '0;
			end else if (cmd.rec == 9'd12) begin
				o_kind  <= KIND_COUNT;
				o_count <= sel_tot_q;
			end else begin
				o_kind  <= KIND_TYPE;
				o_slot  <= 4'(cmd.rec - 9'd13);
				o_count <= tm_q[ti];
				o_apm   <= ta_q[ti];
				o_name  <= tn_q[ti];
				o_sel   <= is_sel(tn_q[ti], sel_name_q);
			end
		end
	end
	assign k6 = 3'(cmd.rec - 9'd6);

endmodule

@@ hw/rtl/abrc_ctrl.sv @@
// Controller: atom intake, frame-end run close and report sequencing.
module abrc_ctrl import abrc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  logic      s_last,
	output logic      in_load,
	output logic      m_tvalid,
	input  logic      m_tready,
	output abrc_cmd_t cmd,
	input  abrc_sts_t sts
);
	typedef enum logic [2:0] {ST_IDLE, ST_ATOM, ST_CLOSE, ST_EMIT, ST_WAIT} st_t;
	st_t        st_q;
	logic       fe_q;
	logic [8:0] rec_q;
	logic [8:0] nrec;

	assign nrec     = 9'd13 + sts.types;
	assign s_tready = (st_q == ST_IDLE);
	assign in_load  = s_tvalid && s_tready;

	always_comb begin
		cmd = '0;
		cmd.rec   = rec_q;
		cmd.last  = (rec_q == nrec - 9'd1);
		cmd.atom  = (st_q == ST_ATOM);
		cmd.close = (st_q == ST_ATOM && fe_q) || (st_q == ST_CLOSE);
		cmd.emit  = (st_q == ST_EMIT);
		cmd.clear = (st_q == ST_WAIT) && m_tready && cmd.last;
		if (st_q == ST_ATOM && fe_q) cmd.close = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; fe_q <= 1'b0; rec_q <= '0; m_tvalid <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: if (in_load) begin
					fe_q <= s_last;
					st_q <= ST_ATOM;
				end
				ST_ATOM: st_q <= fe_q ? ST_CLOSE : ST_IDLE;
				ST_CLOSE: begin
					rec_q <= '0;
					st_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					m_tvalid <= 1'b1;
					st_q     <= ST_WAIT;
				end
				ST_WAIT: if (m_tready) begin
					m_tvalid <= 1'b0;
					if (rec_q == nrec - 9'd1) begin
						st_q <= ST_IDLE;
						fe_q <= 1'b0;
					end else begin
						rec_q <= rec_q + 9'd1;
						st_q  <= ST_EMIT;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	ap_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid) else $error("input taken during report");
	ap_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_EMIT |=> m_tvalid) else $error("emit without valid");
	ap_rec_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> rec_q < nrec) else $error("record past report end");
endmodule

@@ hw/rtl/atom_bounds_and_residue_census.sv @@
// Top level: atom bounds and residue census.
// Atoms are taken one per beat; each atom is first registered, then applied to the state,
// and the block takes no new atom until that update is done. An atom with tlast set adds a
// close step for the open run into the type table, then a report of 13 + (types in use)
// beats follows, each held until the master takes it; no input is taken meanwhile.
// Type lookup is a parallel compare over all TYPE_SLOTS slots.
module atom_bounds_and_residue_census import abrc_pkg::*; #(
	parameter int unsigned TYPE_SLOTS   = DEF_TYPE_SLOTS,
	parameter int unsigned SELECT_NAMES = DEF_SELECT_NAMES
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [39:0]   cfg_data,
	input  logic          s_tvalid,
	output logic          s_tready,
	// residue_number[16:0], residue_name[56:17], pos_x[81:57], pos_y[106:82],
	// pos_z[131:107], zero fill
	input  logic [135:0]  s_tdata,
	input  logic          s_tlast,   // frame_end
	output logic          m_tvalid,
	input  logic          m_tready,
	// record_kind[2:0], slot_index[6:3], coordinate[31:7], bound_found[32],
	// count[56:33], molecule_atoms[73:57], type_name[113:74],
	// type_selected[114], error_code[116:115], zero fill
	output logic [119:0]  m_tdata,
	output logic          m_tlast    // last
);
	abrc_cmd_t cmd;
	abrc_sts_t sts;
	logic      in_load;
	logic [2:0] k; logic [3:0] sl; logic [24:0] co; logic fd; logic [23:0] cn;
	logic [16:0] ap; logic [39:0] nm; logic se; logic [1:0] er;

	abrc_ctrl u_ctrl (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_last(s_tlast), .in_load,
		.m_tvalid, .m_tready, .cmd, .sts
	);

	abrc_dpath #(.TYPE_SLOTS(TYPE_SLOTS), .SELECT_NAMES(SELECT_NAMES)) u_dpath (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .in_load,
		.in_num(s_tdata[16:0]), .in_name(s_tdata[56:17]),
		.in_x(s_tdata[81:57]), .in_y(s_tdata[106:82]), .in_z(s_tdata[131:107]),
		.cmd, .sts, .o_kind(k), .o_slot(sl), .o_coord(co), .o_found(fd),
		.o_count(cn), .o_apm(ap), .o_name(nm), .o_sel(se), .o_err(er), .o_last(m_tlast)
	);

	assign m_tdata = {3'b000, er, se, nm, ap, cn, fd, co, sl, k};
endmodule
